// ===== rtl/timing_histogram_statistics_macros.svh =====
// assertion helpers for the timing histogram block
`ifndef TIMING_HISTOGRAM_STATISTICS_MACROS_SVH
`define TIMING_HISTOGRAM_STATISTICS_MACROS_SVH

`ifndef SYNTHESIS
`define THS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("timing histogram assertion failed");
`define THS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timing histogram assertion failed");
`else
`define THS_ASSERT(label, prop)
`define THS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/ths_pkg.sv =====
package ths_pkg;

	localparam int POSITIONS_DEF   = 16;
	localparam int BYTE_VALUES_DEF = 256;
	localparam int COUNT_BITS_DEF  = 32;

	localparam int MAX_POSITIONS = 16;
	localparam int SUM_W         = 48;
	localparam int SQ_W          = 64;
	localparam int Q8_W          = 24;
	localparam int DIV_W         = SQ_W + 16;
	localparam int ROOT_W        = 2 * Q8_W;
	localparam int IN_DATA_W     = 160;
	localparam int OUT_DATA_W    = 112;

	localparam logic [Q8_W-1:0] Q8_MAX     = 24'hFFFF00;
	localparam logic [15:0]     CLIP_RESET = 16'd10000;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		op_t                          op;
		logic [8*MAX_POSITIONS-1:0]   bytes;
		logic [15:0]                  timing;
		logic [31:0]                  square;
		logic [3:0]                   position;
		logic [7:0]                   byte_value;
	} item_t;

	typedef struct packed {
		logic init_busy;
	} back_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_CLEAR,
		ST_RD_CAP,
		ST_DIV_MEAN,
		ST_DIV_SQ,
		ST_DIV_G,
		ST_VAR,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/timing_histogram_statistics.sv =====
// Byte-value timing profile. Each sample request carries sixteen bytes and one
// timing value; when the timing is below clip_limit, every byte position's bin
// for its byte gets its count, timing sum and sum of squares bumped, all
// saturating. In the back end a sample is one read and one write on the
// per-position bin memories. A readout returns count, mean, standard
// deviation and offset from the global mean in Q8; it runs the bit-serial
// divider (80 steps per division, three divisions, or two when no sample has
// been added since reset or the last clear) and then the 24-step square root;
// an empty or absent bin skips both. A clear zeroes the bin memories, one
// memory row a cycle. After reset the same sweep runs and no request is taken
// until it ends. A two-entry queue sits between the accepting front end and the
// back end, and the result has its own output register.
`include "timing_histogram_statistics_macros.svh"

module timing_histogram_statistics #(
	parameter int POSITIONS   = ths_pkg::POSITIONS_DEF,
	parameter int BYTE_VALUES = ths_pkg::BYTE_VALUES_DEF,
	parameter int COUNT_BITS  = ths_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// bytes_low, bytes_high, timing, position, byte_value, zero fill
	input  logic [ths_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// opcode
	input  logic [1:0]                      s_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [15:0]                     cfg_data,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// bin_samples, mean_q8, deviation_q8, offset_q8, zero fill
	output logic [ths_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// empty_bin
	output logic [0:0]                      m_axis_tuser
);
	import ths_pkg::*;

	item_t        head;
	logic         head_valid;
	logic         pop;
	back_status_t status;

	ths_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.status       (status),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop)
	);

	ths_back #(
		.POSITIONS  (POSITIONS),
		.BYTE_VALUES(BYTE_VALUES),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.status       (status),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// no request is taken while the start-up sweep runs
	`THS_ASSERT(a_no_take_in_init, status.init_busy |-> !s_axis_tready)
	// the start-up sweep happens once
	`THS_ASSERT_NEXT(a_init_once, !status.init_busy, !status.init_busy)
	// an empty bin carries all-zero statistics
	`THS_ASSERT(a_empty_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
	`THS_ASSERT(a_q8_bounds, m_axis_tvalid |-> ((m_axis_tdata[55:32] <= Q8_MAX) && (m_axis_tdata[79:56] <= Q8_MAX)))
endmodule

// ===== rtl/ths_ram.sv =====
module ths_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/ths_div.sv =====
module ths_div #(
	parameter int COUNT_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ths_pkg::DIV_W-1:0]    dividend,
	input  logic [COUNT_BITS-1:0]        divisor,
	output logic                         done,
	output logic [ths_pkg::DIV_W-1:0]    quotient
);
	import ths_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [DIV_W-1:0]      quo_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  fits;

	// one quotient bit a cycle, dividend shifts out as quotient shifts in
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/ths_sqrt.sv =====
module ths_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ths_pkg::ROOT_W-1:0]  value,
	output logic                        done,
	output logic [ths_pkg::Q8_W-1:0]    root
);
	import ths_pkg::*;

	localparam int STEPS = ROOT_W / 2;
	localparam int CW    = $clog2(STEPS + 1);

	logic [ROOT_W-1:0] v_q;
	logic [ROOT_W-1:0] res_q;
	logic [ROOT_W-1:0] bit_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W:0]   trial;
	logic              fits;

	always_comb begin
		trial = {1'b0, res_q} + {1'b0, bit_q};
		fits  = {1'b0, v_q} >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// two radicand bits a step, highest even power first
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			res_q <= '0;
			bit_q <= ROOT_W'(1) << (ROOT_W - 2);
		end else if (busy_q) begin
			if (fits) begin
				v_q   <= v_q - trial[ROOT_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[Q8_W-1:0];
endmodule

// ===== rtl/ths_front.sv =====
module ths_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [ths_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]                     s_axis_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [15:0]                    cfg_data,
	input  ths_pkg::back_status_t          status,
	output ths_pkg::item_t                 head,
	output logic                           head_valid,
	input  logic                           pop
);
	import ths_pkg::*;

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	logic [15:0]       clip_q;
	item_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    fill_q;
	item_t             incoming;
	logic              keep;
	logic              push;

	always_comb begin
		incoming.op         = op_t'(s_axis_tuser);
		incoming.bytes      = s_axis_tdata[127:0];
		incoming.timing     = s_axis_tdata[143:128];
		incoming.square     = {16'b0, s_axis_tdata[143:128]} * {16'b0, s_axis_tdata[143:128]};
		incoming.position   = s_axis_tdata[147:144];
		incoming.byte_value = s_axis_tdata[155:148];
		// clipped samples and the unused code are taken and dropped here
		case (incoming.op)
			OP_ADD:   keep = incoming.timing < clip_q;
			OP_READ:  keep = 1'b1;
			OP_CLEAR: keep = 1'b1;
			default:  keep = 1'b0;
		endcase
		s_axis_tready = (fill_q != (PTR_W+1)'(FIFO_DEPTH)) && !status.init_busy;
		push          = s_axis_tvalid && s_axis_tready && keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= CLIP_RESET;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (cfg_valid) begin
				clip_q <= cfg_data;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= incoming;
		end
	end

	assign cfg_ready  = 1'b1;
	assign head       = fifo_q[rd_ptr_q];
	assign head_valid = fill_q != '0;
endmodule

// ===== rtl/ths_back.sv =====
module ths_back #(
	parameter int POSITIONS   = 16,
	parameter int BYTE_VALUES = 256,
	parameter int COUNT_BITS  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ths_pkg::item_t                  head,
	input  logic                            head_valid,
	output logic                            pop,
	output ths_pkg::back_status_t           status,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [ths_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic [0:0]                      m_axis_tuser
);
	import ths_pkg::*;

	localparam int AW        = $clog2(BYTE_VALUES);
	localparam int PW        = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
	localparam int RW        = COUNT_BITS + SUM_W + SQ_W;
	localparam int MEAN_FRAC = 8;
	localparam int SQ_FRAC   = DIV_W - SQ_W;
	localparam int SUM_PAD   = DIV_W - SUM_W - MEAN_FRAC;
	localparam int OUT_USED  = 32 + 3 * Q8_W + 1;

	state_t                 state_q, state_d;
	logic [AW-1:0]          clr_q;
	logic                   init_q;
	logic [COUNT_BITS-1:0]  total_cnt_q;
	logic [SUM_W-1:0]       total_sum_q;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic                   out_empty_q;

	item_t                  cur_q;
	logic [PW-1:0]          sel_q;
	logic                   sel_ok_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   empty_q;
	logic [Q8_W-1:0]        mean_q, gmean_q, dev_q;
	logic [ROOT_W-1:0]      msq_q, m2_q;

	logic [AW-1:0]          rd_addr [POSITIONS];
	logic                   wr_en   [POSITIONS];
	logic [AW-1:0]          wr_addr [POSITIONS];
	logic [RW-1:0]          wr_data [POSITIONS];
	logic [RW-1:0]          rd_data [POSITIONS];

	logic [COUNT_BITS-1:0]  sel_cnt;
	logic [SUM_W-1:0]       sel_sum;
	logic [SQ_W-1:0]        sel_sq;
	logic                   rd_empty;
	logic                   clr_last;
	logic                   head_ok;
	logic                   out_free;
	logic                   div_start, div_done;
	logic [DIV_W-1:0]       div_dividend, div_quot;
	logic [COUNT_BITS-1:0]  div_divisor;
	logic                   sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]      sqrt_value;
	logic [Q8_W-1:0]        sqrt_root;
	logic [COUNT_BITS+31:0] cnt_wide;
	logic [31:0]            samples;
	logic [Q8_W:0]          offset;
	logic [COUNT_BITS:0]    tot_cnt_inc;
	logic [SUM_W:0]         tot_sum_add;

	function automatic logic [Q8_W-1:0] clamp_q8(input logic [DIV_W-1:0] v);
		clamp_q8 = (v > DIV_W'(Q8_MAX)) ? Q8_MAX : v[Q8_W-1:0];
	endfunction

	// integer part limited to 32 bits, fraction kept
	function automatic logic [ROOT_W-1:0] clamp_q16(input logic [DIV_W-1:0] v);
		if (v[DIV_W-1:ROOT_W] != '0) begin
			clamp_q16 = {32'hFFFF_FFFF, v[SQ_FRAC-1:0]};
		end else begin
			clamp_q16 = v[ROOT_W-1:0];
		end
	endfunction

	for (genvar p = 0; p < POSITIONS; p++) begin : g_lane
		logic [7:0]            head_byte, cur_byte;
		logic [COUNT_BITS-1:0] cnt_old, cnt_new;
		logic [SUM_W-1:0]      sum_old, sum_new;
		logic [SUM_W:0]        sum_add;
		logic [SQ_W-1:0]       sq_old, sq_new;
		logic [SQ_W:0]         sq_add;

		always_comb begin
			head_byte  = head.bytes[8*p +: 8];
			cur_byte   = cur_q.bytes[8*p +: 8];
			rd_addr[p] = (head.op == OP_READ) ? head.byte_value[AW-1:0] : head_byte[AW-1:0];
			{cnt_old, sum_old, sq_old} = rd_data[p];
			cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + COUNT_BITS'(1);
			sum_add = {1'b0, sum_old} + (SUM_W+1)'(cur_q.timing);
			sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
			sq_add  = {1'b0, sq_old} + (SQ_W+1)'(cur_q.square);
			sq_new  = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
			wr_en[p]   = 1'b0;
			wr_addr[p] = cur_byte[AW-1:0];
			wr_data[p] = {cnt_new, sum_new, sq_new};
			case (state_q)
				ST_CLEAR: begin
					wr_en[p]   = 1'b1;
					wr_addr[p] = clr_q;
					wr_data[p] = '0;
				end
				ST_ADD_WR: wr_en[p] = {1'b0, cur_byte} < 9'(BYTE_VALUES);
				default: ;
			endcase
		end

		ths_ram #(
			.WIDTH(RW),
			.DEPTH(BYTE_VALUES)
		) u_ram (
			.clk  (clk),
			.we   (wr_en[p]),
			.waddr(wr_addr[p]),
			.wdata(wr_data[p]),
			.raddr(rd_addr[p]),
			.rdata(rd_data[p])
		);
	end

	ths_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quot)
	);

	ths_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.value (sqrt_value),
		.done  (sqrt_done),
		.root  (sqrt_root)
	);

	always_comb begin
		{sel_cnt, sel_sum, sel_sq} = rd_data[sel_q];
		rd_empty    = !sel_ok_q || (sel_cnt == '0);
		clr_last    = clr_q == AW'(BYTE_VALUES - 1);
		head_ok     = ({1'b0, head.position} < 5'(POSITIONS)) &&
			({1'b0, head.byte_value} < 9'(BYTE_VALUES));
		out_free    = !out_valid_q || m_axis_tready;
		sqrt_value  = (msq_q > m2_q) ? msq_q - m2_q : '0;
		cnt_wide    = {32'b0, cnt_q};
		samples     = (cnt_wide > (COUNT_BITS+32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF :
			cnt_wide[31:0];
		offset      = {1'b0, mean_q} - {1'b0, gmean_q};
		tot_cnt_inc = {1'b0, total_cnt_q} + (COUNT_BITS+1)'(1);
		tot_sum_add = {1'b0, total_sum_q} + (SUM_W+1)'(head.timing);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					case (head.op)
						OP_ADD:   state_d = ST_ADD_WR;
						OP_READ:  state_d = ST_RD_CAP;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_WR: state_d = ST_IDLE;
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_CAP: state_d = rd_empty ? ST_OUT : ST_DIV_MEAN;
			ST_DIV_MEAN: begin
				if (div_done) begin
					state_d = ST_DIV_SQ;
				end
			end
			ST_DIV_SQ: begin
				if (div_done) begin
					state_d = (total_cnt_q != '0) ? ST_DIV_G : ST_VAR;
				end
			end
			ST_DIV_G: begin
				if (div_done) begin
					state_d = ST_VAR;
				end
			end
			ST_VAR: state_d = ST_SQRT;
			ST_SQRT: begin
				if (sqrt_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop          = 1'b0;
		div_start    = 1'b0;
		div_dividend = {{SUM_PAD{1'b0}}, sel_sum, MEAN_FRAC'(0)};
		div_divisor  = sel_cnt;
		sqrt_start   = 1'b0;
		case (state_q)
			ST_IDLE:   pop = head_valid;
			ST_RD_CAP: div_start = !rd_empty;
			ST_DIV_MEAN: begin
				div_start    = div_done;
				div_dividend = {sq_q, SQ_FRAC'(0)};
				div_divisor  = cnt_q;
			end
			ST_DIV_SQ: begin
				div_start    = div_done && (total_cnt_q != '0);
				div_dividend = {{SUM_PAD{1'b0}}, total_sum_q, MEAN_FRAC'(0)};
				div_divisor  = total_cnt_q;
			end
			ST_VAR: sqrt_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			init_q      <= 1'b1;
			total_cnt_q <= '0;
			total_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + AW'(1);
				if (clr_last) begin
					init_q <= 1'b0;
				end
			end
			if (pop && head.op == OP_ADD) begin
				total_cnt_q <= tot_cnt_inc[COUNT_BITS] ? total_cnt_q :
					tot_cnt_inc[COUNT_BITS-1:0];
				total_sum_q <= tot_sum_add[SUM_W] ? '1 : tot_sum_add[SUM_W-1:0];
			end
			if (pop && head.op == OP_CLEAR) begin
				total_cnt_q <= '0;
				total_sum_q <= '0;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q    <= head;
			sel_q    <= head.position[PW-1:0];
			sel_ok_q <= head_ok;
		end
		if (state_q == ST_RD_CAP) begin
			cnt_q   <= sel_cnt;
			sq_q    <= sel_sq;
			empty_q <= rd_empty;
		end
		if (state_q == ST_DIV_MEAN && div_done) begin
			mean_q <= clamp_q8(div_quot);
		end
		if (state_q == ST_DIV_SQ) begin
			m2_q <= mean_q * mean_q;
			if (div_done) begin
				msq_q <= clamp_q16(div_quot);
				if (total_cnt_q == '0) begin
					gmean_q <= '0;
				end
			end
		end
		if (state_q == ST_DIV_G && div_done) begin
			gmean_q <= clamp_q8(div_quot);
		end
		if (state_q == ST_SQRT && sqrt_done) begin
			dev_q <= (sqrt_root > Q8_MAX) ? Q8_MAX : sqrt_root;
		end
		if (state_q == ST_OUT && out_free) begin
			out_empty_q <= empty_q;
			out_data_q  <= empty_q ? '0 :
				{{(OUT_DATA_W-OUT_USED){1'b0}}, offset, dev_q, mean_q, samples};
		end
	end

	assign status.init_busy = init_q;
	assign m_axis_tvalid    = out_valid_q;
	assign m_axis_tdata     = out_data_q;
	assign m_axis_tuser     = out_empty_q;
endmodule
